### sv/gtg_pkg.sv
`default_nettype none
package gtg_pkg;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SETUP,
      ST_HALVE,
      ST_SQX,
      ST_SQY,
      ST_SQGO,
      ST_SQRT,
      ST_DCHK,
      ST_NORM,
      ST_CORDIC,
      ST_MODA,
      ST_MODI,
      ST_MULL,
      ST_RNDL,
      ST_MULA,
      ST_RNDA,
      ST_TURN,
      ST_OUT
   } state_type;

   localparam logic [1:0] PH_DRIVE = 2'd0;
   localparam logic [1:0] PH_TURN  = 2'd1;
   localparam logic [1:0] PH_DONE  = 2'd2;

   localparam logic [2:0] CSR_GOAL_X       = 3'd0;
   localparam logic [2:0] CSR_GOAL_Y       = 3'd1;
   localparam logic [2:0] CSR_GOAL_HEADING = 3'd2;
   localparam logic [2:0] CSR_GAIN_LINEAR  = 3'd3;
   localparam logic [2:0] CSR_GAIN_ANGULAR = 3'd4;
   localparam logic [2:0] CSR_DIST_TOL     = 3'd5;
   localparam logic [2:0] CSR_HEAD_TOL     = 3'd6;

   localparam logic [15:0] GAIN_LINEAR_RST  = 16'd1638;
   localparam logic [15:0] GAIN_ANGULAR_RST = 16'd6144;
   localparam logic [14:0] DIST_TOL_RST     = 15'd102;
   localparam logic [13:0] HEAD_TOL_RST     = 14'd8;

   localparam int PI_Q13       = 25736;
   localparam int TWO_PI_Q13   = 2 * PI_Q13;
   localparam int CORDIC_STEPS = 14;

   // arctangent of 2^-i in q3.13
   function automatic logic [12:0] atan_q13(input logic [3:0] i);
      logic [12:0] r;
      case (i)
         4'd0:    r = 13'd6434;
         4'd1:    r = 13'd3798;
         4'd2:    r = 13'd2007;
         4'd3:    r = 13'd1019;
         4'd4:    r = 13'd511;
         4'd5:    r = 13'd256;
         4'd6:    r = 13'd128;
         4'd7:    r = 13'd64;
         4'd8:    r = 13'd32;
         4'd9:    r = 13'd16;
         4'd10:   r = 13'd8;
         4'd11:   r = 13'd4;
         4'd12:   r = 13'd2;
         4'd13:   r = 13'd1;
         default: r = 13'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### sv/go_to_goal_pose_controller.sv
`default_nettype none
// go-to-goal pose controller for a unicycle robot
// req channel: one measured pose per item (x, y, heading in tdata, start flag in tuser).
// rsp channel: one command per item (linear and angular velocity in tdata, phase in tuser).
// csr channel: register writes by index (goal, gains, tolerances), ready out of reset;
// write only while no item is in flight.
// one item is worked on at a time. a driving item passes through the setup, halving
// and squaring steps, the root (DATA_WIDTH+2 digits and a finish step), a tolerance
// check, the scaling steps, 14 cordic iterations, the modulo steps (DATA_WIDTH-13
// after the first) and 4 multiply and round steps before the output step. the next
// item can be taken in the cycle after the result is loaded.
// the result is held in an output register, so the next pose is taken while the
// command waits; when the receiver stalls the block stops at its final step until
// the register frees.
// reset puts the controller in the done phase with the register reset values; the
// next pose with start set begins driving.
module go_to_goal_pose_controller #(
   parameter int DATA_WIDTH = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // pose_x, pose_y, pose_heading
   input  wire logic [((3*DATA_WIDTH+7)/8)*8-1:0] req_tdata,
   // start_req
   input  wire logic req_tuser,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // linear_velocity, angular_velocity
   output logic [((2*DATA_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // phase
   output logic [1:0] rsp_tuser,
   input  wire logic csr_valid,
   output logic      csr_ready,
   input  wire logic [2:0] csr_index,
   input  wire logic [((DATA_WIDTH > 16) ? DATA_WIDTH : 16)-1:0] csr_data
);

   localparam int W = DATA_WIDTH;
   localparam int RSP_TW = ((2*W+7)/8)*8;
   localparam int AW = W + 1;
   localparam int MW = (AW > 31) ? 31 : AW;
   localparam int NW = 2*AW + 2;
   localparam int DW = AW + 4;
   localparam int BW = DW + 1;
   localparam int PW = 17 + BW;
   localparam int CW = 45;
   localparam int ZW = 18;
   localparam int VW = W + 8;
   localparam int MODK = (W > 15) ? W - 14 : 1;

   localparam logic signed [CW-1:0] LIM40 = CW'(64'd1 << 40);
   localparam logic signed [CW-1:0] LIM32 = CW'(64'd1 << 32);
   localparam logic signed [ZW-1:0] PI_Z = ZW'(gtg_pkg::PI_Q13);
   localparam logic signed [VW-1:0] PI_V = VW'(gtg_pkg::PI_Q13);
   localparam logic signed [VW-1:0] TWO_PI_V = VW'(gtg_pkg::TWO_PI_Q13);
   localparam logic signed [PW:0] SAT_HI = (PW+1)'((64'sd1 <<< (W-1)) - 64'sd1);
   localparam logic signed [PW:0] SAT_LO = -SAT_HI - (PW+1)'(1);

   gtg_pkg::state_type state_ff, state_in;
   logic [1:0] phase_ff, phase_in;

   logic [W-1:0]  goal_x_ff, goal_y_ff, goal_h_ff;
   logic [15:0]   kl_ff, ka_ff;
   logic [14:0]   dtol_ff;
   logic [13:0]   htol_ff;

   logic signed [W-1:0] px_ff, px_in, py_ff, py_in, ph_ff, ph_in;
   logic          start_ff, start_in;
   logic signed [W:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [AW-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [1:0]    s_ff, s_in;
   logic [NW-1:0] sq_ff, sq_in;
   logic [DW-1:0] dist_ff, dist_in;
   logic signed [CW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic signed [VW-1:0] v_ff, v_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [W-1:0]  lin_ff, lin_in, ang_ff, ang_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]  out_lin_ff, out_lin_in, out_ang_ff, out_ang_in;
   logic [1:0]    out_phase_ff, out_phase_in;

   logic [2*MW-1:0] sqx_w, sqy_w;
   logic          sqrt_start, sqrt_done;
   logic [NW/2-1:0] sqrt_root;

   assign sqx_w = ax_ff[MW-1:0] * ax_ff[MW-1:0];
   assign sqy_w = ay_ff[MW-1:0] * ay_ff[MW-1:0];

   gtg_isqrt #(.RAD_WIDTH(NW)) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sq_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   function automatic logic [W-1:0] round_sat(input logic signed [PW-1:0] p,
                                              input logic wide);
      logic signed [PW:0] t;
      logic [W-1:0] r;
      t = $signed({p[PW-1], p}) + (wide ? (PW+1)'(32'sd16384) : (PW+1)'(32'sd2048));
      t = wide ? (t >>> 15) : (t >>> 12);
      if (t > SAT_HI) r = SAT_HI[W-1:0];
      else if (t < SAT_LO) r = SAT_LO[W-1:0];
      else r = t[W-1:0];
      return r;
   endfunction

   always_comb begin
      logic signed [W:0] err_w;
      logic [W:0] aerr;
      logic [1:0] ph_sel;
      logic signed [CW-1:0] xs, ys;
      logic signed [ZW-1:0] atan_z;
      logic signed [VW-1:0] va, csh;
      logic signed [BW-1:0] alpha_w;
      logic big, in40, in32;

      err_w = $signed({goal_h_ff[W-1], goal_h_ff}) - $signed({ph_ff[W-1], ph_ff});
      aerr = err_w[W] ? $unsigned(-err_w) : $unsigned(err_w);
      ph_sel = start_ff ? gtg_pkg::PH_DRIVE
                        : ((phase_ff > gtg_pkg::PH_DONE) ? gtg_pkg::PH_DONE : phase_ff);
      xs = cx_ff >>> cnt_ff[3:0];
      ys = cy_ff >>> cnt_ff[3:0];
      atan_z = $signed(ZW'(gtg_pkg::atan_q13(cnt_ff[3:0])));
      va = VW'(z_ff) - VW'(ph_ff) + PI_V;
      csh = TWO_PI_V <<< cnt_ff;
      alpha_w = BW'(v_ff - PI_V);
      big = (64'(ax_ff) >= 64'h8000_0000) || (64'(ay_ff) >= 64'h8000_0000);
      in40 = (cx_ff > -LIM40) && (cx_ff < LIM40) && (cy_ff > -LIM40) && (cy_ff < LIM40);
      in32 = (cx_ff > -LIM32) && (cx_ff < LIM32) && (cy_ff > -LIM32) && (cy_ff < LIM32);

      state_in = state_ff;
      phase_in = phase_ff;
      px_in = px_ff;
      py_in = py_ff;
      ph_in = ph_ff;
      start_in = start_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      ax_in = ax_ff;
      ay_in = ay_ff;
      s_in = s_ff;
      sq_in = sq_ff;
      dist_in = dist_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      z_in = z_ff;
      v_in = v_ff;
      cnt_in = cnt_ff;
      prod_in = prod_ff;
      lin_in = lin_ff;
      ang_in = ang_ff;
      out_lin_in = out_lin_ff;
      out_ang_in = out_ang_ff;
      out_phase_in = out_phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      sqrt_start = 1'b0;
      req_tready = (state_ff == gtg_pkg::ST_IDLE) && !reset;

      case (state_ff)
         gtg_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               px_in = req_tdata[W-1:0];
               py_in = req_tdata[2*W-1:W];
               ph_in = req_tdata[3*W-1:2*W];
               start_in = req_tuser;
               state_in = gtg_pkg::ST_SETUP;
            end
         end
         gtg_pkg::ST_SETUP: begin
            dx_in = $signed({goal_x_ff[W-1], goal_x_ff}) - $signed({px_ff[W-1], px_ff});
            dy_in = $signed({goal_y_ff[W-1], goal_y_ff}) - $signed({py_ff[W-1], py_ff});
            ax_in = dx_in[W] ? $unsigned(-dx_in) : $unsigned(dx_in);
            ay_in = dy_in[W] ? $unsigned(-dy_in) : $unsigned(dy_in);
            s_in = '0;
            phase_in = ph_sel;
            if (ph_sel == gtg_pkg::PH_DRIVE) begin
               state_in = gtg_pkg::ST_HALVE;
            end else if (ph_sel == gtg_pkg::PH_TURN) begin
               state_in = gtg_pkg::ST_TURN;
            end else begin
               lin_in = '0;
               ang_in = '0;
               state_in = gtg_pkg::ST_OUT;
            end
         end
         gtg_pkg::ST_HALVE: begin
            // only very wide offsets need this before squaring
            if (big) begin
               ax_in = ax_ff >> 1;
               ay_in = ay_ff >> 1;
               s_in = s_ff + 2'd1;
            end else begin
               state_in = gtg_pkg::ST_SQX;
            end
         end
         gtg_pkg::ST_SQX: begin
            sq_in = NW'(sqx_w);
            state_in = gtg_pkg::ST_SQY;
         end
         gtg_pkg::ST_SQY: begin
            sq_in = sq_ff + NW'(sqy_w);
            state_in = gtg_pkg::ST_SQGO;
         end
         gtg_pkg::ST_SQGO: begin
            sqrt_start = 1'b1;
            state_in = gtg_pkg::ST_SQRT;
         end
         gtg_pkg::ST_SQRT: begin
            if (sqrt_done) begin
               dist_in = DW'(sqrt_root) << s_ff;
               state_in = gtg_pkg::ST_DCHK;
            end
         end
         gtg_pkg::ST_DCHK: begin
            cx_in = CW'(dx_ff);
            cy_in = CW'(dy_ff);
            z_in = '0;
            if (64'(dist_ff) > 64'(dtol_ff)) begin
               if (dx_ff == '0 && dy_ff == '0) state_in = gtg_pkg::ST_MODA;
               else state_in = gtg_pkg::ST_NORM;
            end else begin
               phase_in = gtg_pkg::PH_TURN;
               state_in = gtg_pkg::ST_TURN;
            end
         end
         gtg_pkg::ST_NORM: begin
            // scale up until one component reaches 2^40, eight doublings at a time when safe
            cnt_in = '0;
            if (in40) begin
               cx_in = in32 ? (cx_ff <<< 8) : (cx_ff <<< 1);
               cy_in = in32 ? (cy_ff <<< 8) : (cy_ff <<< 1);
            end else begin
               if (cx_ff < 0) begin
                  z_in = (cy_ff >= 0) ? PI_Z : -PI_Z;
                  cx_in = -cx_ff;
                  cy_in = -cy_ff;
               end
               state_in = gtg_pkg::ST_CORDIC;
            end
         end
         gtg_pkg::ST_CORDIC: begin
            if (cy_ff >= 0) begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               z_in = z_ff + atan_z;
            end else begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               z_in = z_ff - atan_z;
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(gtg_pkg::CORDIC_STEPS - 1)) state_in = gtg_pkg::ST_MODA;
         end
         gtg_pkg::ST_MODA: begin
            // bring the wrap argument positive, then strip multiples of two pi
            v_in = (va < 0) ? (va + (TWO_PI_V <<< MODK)) : va;
            cnt_in = 6'(MODK);
            state_in = gtg_pkg::ST_MODI;
         end
         gtg_pkg::ST_MODI: begin
            if (v_ff >= csh) v_in = v_ff - csh;
            if (cnt_ff == '0) state_in = gtg_pkg::ST_MULL;
            else cnt_in = cnt_ff - 6'd1;
         end
         gtg_pkg::ST_MULL: begin
            prod_in = $signed({1'b0, kl_ff}) * $signed({1'b0, dist_ff});
            state_in = gtg_pkg::ST_RNDL;
         end
         gtg_pkg::ST_RNDL: begin
            lin_in = round_sat(prod_ff, 1'b0);
            state_in = gtg_pkg::ST_MULA;
         end
         gtg_pkg::ST_MULA: begin
            prod_in = $signed({1'b0, ka_ff}) * alpha_w;
            state_in = gtg_pkg::ST_RNDA;
         end
         gtg_pkg::ST_RNDA: begin
            ang_in = round_sat(prod_ff, 1'b1);
            state_in = gtg_pkg::ST_OUT;
         end
         gtg_pkg::ST_TURN: begin
            lin_in = '0;
            if (64'(aerr) > 64'(htol_ff)) begin
               prod_in = $signed({1'b0, ka_ff}) * BW'(err_w);
               state_in = gtg_pkg::ST_RNDA;
            end else begin
               phase_in = gtg_pkg::PH_DONE;
               ang_in = '0;
               state_in = gtg_pkg::ST_OUT;
            end
         end
         gtg_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_lin_in = lin_ff;
               out_ang_in = ang_ff;
               out_phase_in = phase_ff;
               rsp_valid_in = 1'b1;
               state_in = gtg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gtg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gtg_pkg::ST_IDLE;
         phase_ff <= gtg_pkg::PH_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      px_ff <= px_in;
      py_ff <= py_in;
      ph_ff <= ph_in;
      start_ff <= start_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      s_ff <= s_in;
      sq_ff <= sq_in;
      dist_ff <= dist_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      z_ff <= z_in;
      v_ff <= v_in;
      cnt_ff <= cnt_in;
      prod_ff <= prod_in;
      lin_ff <= lin_in;
      ang_ff <= ang_in;
      out_lin_ff <= out_lin_in;
      out_ang_ff <= out_ang_in;
      out_phase_ff <= out_phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff <= '0;
         goal_y_ff <= '0;
         goal_h_ff <= '0;
         kl_ff <= gtg_pkg::GAIN_LINEAR_RST;
         ka_ff <= gtg_pkg::GAIN_ANGULAR_RST;
         dtol_ff <= gtg_pkg::DIST_TOL_RST;
         htol_ff <= gtg_pkg::HEAD_TOL_RST;
      end else if (csr_valid) begin
         case (csr_index)
            gtg_pkg::CSR_GOAL_X:       goal_x_ff <= csr_data[W-1:0];
            gtg_pkg::CSR_GOAL_Y:       goal_y_ff <= csr_data[W-1:0];
            gtg_pkg::CSR_GOAL_HEADING: goal_h_ff <= csr_data[W-1:0];
            gtg_pkg::CSR_GAIN_LINEAR:  kl_ff <= csr_data[15:0];
            gtg_pkg::CSR_GAIN_ANGULAR: ka_ff <= csr_data[15:0];
            gtg_pkg::CSR_DIST_TOL:     dtol_ff <= csr_data[14:0];
            gtg_pkg::CSR_HEAD_TOL:     htol_ff <= csr_data[13:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = RSP_TW'({out_ang_ff, out_lin_ff});
   assign rsp_tuser = out_phase_ff;

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_phase_ff == gtg_pkg::PH_DONE) |-> (out_lin_ff == '0 && out_ang_ff == '0))
      else $error("done command with nonzero velocity");

   a_turn_no_lin: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_phase_ff == gtg_pkg::PH_TURN) |-> (out_lin_ff == '0))
      else $error("turning command with forward speed");

   a_accept_setup: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == gtg_pkg::ST_SETUP))
      else $error("accepted item did not start");

   a_sqrt_done: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> (state_ff == gtg_pkg::ST_SQRT))
      else $error("root finished outside its wait step");

endmodule
`default_nettype wire

### sv/gtg_isqrt.sv
`default_nettype none
module gtg_isqrt #(
   parameter int RAD_WIDTH = 36
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [RAD_WIDTH-1:0]   radicand,
   output logic                        done,
   output logic [RAD_WIDTH/2-1:0]      root
);

   localparam int HW = RAD_WIDTH / 2;
   localparam int NCW = $clog2(HW + 1);

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [NCW-1:0] cnt_ff, cnt_in;
   logic [RAD_WIDTH-1:0] n_ff, n_in;
   logic [HW:0]    rem_ff, rem_in;
   logic [HW-1:0]  root_ff, root_in;

   logic [HW+2:0]  rem_t;
   logic [HW+2:0]  trial;
   logic           ge;

   // two radicand bits per cycle, one root bit per cycle
   always_comb begin
      rem_t = {rem_ff, n_ff[RAD_WIDTH-1 -: 2]};
      trial = {1'b0, root_ff, 2'b01};
      ge = (rem_t >= trial);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      n_in = n_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         n_in = radicand;
         rem_in = '0;
         root_in = '0;
      end else if (busy_ff) begin
         n_in = {n_ff[RAD_WIDTH-3:0], 2'b00};
         rem_in = ge ? (HW+1)'(rem_t - trial) : rem_t[HW:0];
         root_in = {root_ff[HW-2:0], ge};
         cnt_in = cnt_ff + NCW'(1);
         if (cnt_ff == NCW'(HW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      n_ff <= n_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire
